### src/mcg_pkg.sv
// ----------------------------------------------------------------------------
// mcg_pkg
// shared types, constants and calendar tables for the month grid generator
// ----------------------------------------------------------------------------
package mcg_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int LEAD_W  = 3;

  localparam logic [YEAR_W-1:0]  YEAR_MIN  = 14'd1;
  localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  // reciprocal constants: floor(x * R >> S) == floor(x / D) over the used range
  localparam int RECIP100 = 5243;
  localparam int SHIFT100 = 19;
  localparam int RECIP7   = 9363;
  localparam int SHIFT7   = 16;

  // per-request parameters handed from the setup pipeline to the cell emitter
  typedef struct packed {
    logic               bad;
    logic [LEAD_W-1:0]  lead;
    logic [DAY_W-1:0]   plen;
    logic [DAY_W-1:0]   len;
    logic [YEAR_W-1:0]  py;
    logic [MONTH_W-1:0] pm;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  ny;
    logic [MONTH_W-1:0] nm;
  } req_params_t;

  // days in month, february from the leap flag
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
    logic [DAY_W-1:0] d;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
      4'd2: d = leap ? 5'd29 : 5'd28;
      default: d = 5'd0;
    endcase
    return d;
  endfunction

  // weekday offset of the 1st for each month
  function automatic logic [2:0] wd_offset(input logic [MONTH_W-1:0] m);
    logic [2:0] o;
    case (m)
      4'd1:  o = 3'd0;
      4'd2:  o = 3'd3;
      4'd3:  o = 3'd2;
      4'd4:  o = 3'd5;
      4'd5:  o = 3'd0;
      4'd6:  o = 3'd3;
      4'd7:  o = 3'd5;
      4'd8:  o = 3'd1;
      4'd9:  o = 3'd4;
      4'd10: o = 3'd6;
      4'd11: o = 3'd2;
      4'd12: o = 3'd4;
      default: o = 3'd0;
    endcase
    return o;
  endfunction

endpackage

### src/mcg_setup.sv
// ----------------------------------------------------------------------------
// mcg_setup
// four-stage pipeline that turns a year and month into grid parameters
// ----------------------------------------------------------------------------
module mcg_setup import mcg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic [YEAR_W-1:0]  req_year,
  input  logic [MONTH_W-1:0] req_month,
  output logic               prm_valid,
  input  logic               prm_ready,
  output req_params_t        prm
);

  // stage 1: captured request
  logic               v1;
  logic [YEAR_W-1:0]  year1;
  logic [MONTH_W-1:0] month1;
  logic               bad1;
  logic [YEAR_W-1:0]  yy1;

  // stage 2: quotients
  logic               v2;
  logic [YEAR_W-1:0]  year2;
  logic [MONTH_W-1:0] month2;
  logic               bad2;
  logic [YEAR_W-1:0]  yy2;
  logic [7:0]         q100_2;
  logic [5:0]         q400_2;
  logic [7:0]         yq100_2;
  logic [5:0]         yq400_2;

  // stage 3: weekday sum and leap flag
  logic               v3;
  logic [YEAR_W-1:0]  year3;
  logic [MONTH_W-1:0] month3;
  logic               bad3;
  logic [14:0]        sum3;
  logic               leap3;

  // stage 4: mod-7 quotient
  logic               v4;
  logic [YEAR_W-1:0]  year4;
  logic [MONTH_W-1:0] month4;
  logic               bad4;
  logic [14:0]        sum4;
  logic [12:0]        q7_4;
  logic               leap4;

  logic rdy2, rdy3, rdy4;

  assign rdy4      = !v4 || prm_ready;
  assign rdy3      = !v3 || rdy4;
  assign rdy2      = !v2 || rdy3;
  assign req_ready = !v1 || rdy2;

  logic [26:0] p100, p400, py100, py400;
  logic [14:0] chk100, chk400;
  logic [14:0] sum_next;
  logic [28:0] p7;

  assign p100  = 27'(yy1) * 27'(RECIP100);
  assign p400  = 27'(yy1[YEAR_W-1:2]) * 27'(RECIP100);
  assign py100 = 27'(year1) * 27'(RECIP100);
  assign py400 = 27'(year1[YEAR_W-1:2]) * 27'(RECIP100);

  assign chk100 = 15'(yq100_2) * 15'd100;
  assign chk400 = 15'(yq400_2) * 15'd400;

  assign sum_next = 15'(yy2) + 15'(yy2[YEAR_W-1:2]) - 15'(q100_2) + 15'(q400_2)
                  + 15'(wd_offset(month2)) + 15'd1;

  assign p7 = 29'(sum3) * 29'(RECIP7);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (req_ready) v1 <= req_valid;
      if (rdy2)      v2 <= v1;
      if (rdy3)      v3 <= v2;
      if (rdy4)      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      year1  <= req_year;
      month1 <= req_month;
      bad1   <= (req_year < YEAR_MIN) || (req_year > YEAR_MAX) ||
                (req_month < MONTH_JAN) || (req_month > MONTH_DEC);
      yy1    <= (req_month < MONTH_MAR) ? req_year - YEAR_MIN : req_year;
    end
    if (rdy2) begin
      year2   <= year1;
      month2  <= month1;
      bad2    <= bad1;
      yy2     <= yy1;
      q100_2  <= p100[SHIFT100 +: 8];
      q400_2  <= p400[SHIFT100 +: 6];
      yq100_2 <= py100[SHIFT100 +: 8];
      yq400_2 <= py400[SHIFT100 +: 6];
    end
    if (rdy3) begin
      year3  <= year2;
      month3 <= month2;
      bad3   <= bad2;
      sum3   <= sum_next;
      leap3  <= (year2[1:0] == 2'b00) &&
                ((chk100 != 15'(year2)) || (chk400 == 15'(year2)));
    end
    if (rdy4) begin
      year4  <= year3;
      month4 <= month3;
      bad4   <= bad3;
      sum4   <= sum3;
      q7_4   <= p7[SHIFT7 +: 13];
      leap4  <= leap3;
    end
  end

  // remainder mod 7 and neighbor months
  logic [14:0] rem7;
  assign rem7 = sum4 - ((15'(q7_4) << 3) - 15'(q7_4));

  always_comb begin
    prm.bad   = bad4;
    prm.lead  = rem7[LEAD_W-1:0];
    prm.year  = year4;
    prm.month = month4;
    if (month4 == MONTH_JAN) begin
      prm.pm = MONTH_DEC;
      prm.py = year4 - YEAR_MIN;
    end else begin
      prm.pm = month4 - 4'd1;
      prm.py = year4;
    end
    if (month4 == MONTH_DEC) begin
      prm.nm = MONTH_JAN;
      prm.ny = year4 + YEAR_MIN;
    end else begin
      prm.nm = month4 + 4'd1;
      prm.ny = year4;
    end
    prm.len  = month_days(month4, leap4 && (month4 == MONTH_FEB));
    prm.plen = month_days(prm.pm, leap4 && (month4 == MONTH_MAR));
  end

  assign prm_valid = v4;

endmodule

### src/mcg_cells.sv
// ----------------------------------------------------------------------------
// mcg_cells
// cell counter and output register, one grid cell per cycle while cell_ready does not stall
// ----------------------------------------------------------------------------
module mcg_cells import mcg_pkg::*; #(
  parameter int GRID_CELLS = 42
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               prm_valid,
  output logic               prm_ready,
  input  req_params_t        prm,
  output logic               cell_valid,
  input  logic               cell_ready,
  output logic [YEAR_W-1:0]  cell_year,
  output logic [MONTH_W-1:0] cell_month,
  output logic [DAY_W-1:0]   cell_day,
  output logic               cell_this_month,
  output logic               date_ok,
  output logic               bad_request,
  output logic               last_cell
);

  localparam int KW = $clog2(GRID_CELLS);
  localparam int CW = KW + 2;
  localparam logic [KW-1:0] K_LAST = KW'(GRID_CELLS - 1);

  logic              busy;
  logic [KW-1:0]     k;
  req_params_t       p;

  logic              step, last_now;
  logic [CW-1:0]     kc, lead_c, mid_end;
  logic [YEAR_W-1:0] y_c;
  logic [MONTH_W-1:0] m_c;
  logic [CW-1:0]     d_c;
  logic              inm_c;

  assign step      = busy && (!cell_valid || cell_ready);
  assign last_now  = p.bad || (k == K_LAST);
  assign prm_ready = !busy || (step && last_now);

  assign kc      = CW'(k);
  assign lead_c  = CW'(p.lead);
  assign mid_end = lead_c + CW'(p.len);

  always_comb begin
    if (kc < lead_c) begin
      y_c   = p.py;
      m_c   = p.pm;
      d_c   = CW'(p.plen) - lead_c + kc + CW'(1);
      inm_c = 1'b0;
    end else if (kc < mid_end) begin
      y_c   = p.year;
      m_c   = p.month;
      d_c   = kc - lead_c + CW'(1);
      inm_c = 1'b1;
    end else begin
      y_c   = p.ny;
      m_c   = p.nm;
      d_c   = kc - mid_end + CW'(1);
      inm_c = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      k          <= '0;
      cell_valid <= 1'b0;
    end else begin
      if (step) begin
        cell_valid <= 1'b1;
      end else if (cell_ready) begin
        cell_valid <= 1'b0;
      end
      // a new request may start in the cycle the last cell goes out
      if (prm_valid && prm_ready) begin
        busy <= 1'b1;
        k    <= '0;
      end else if (step) begin
        k <= k + KW'(1);
        if (last_now) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (prm_valid && prm_ready) p <= prm;
    if (step) begin
      if (p.bad) begin
        cell_year       <= '0;
        cell_month      <= '0;
        cell_day        <= '0;
        cell_this_month <= 1'b0;
        date_ok         <= 1'b0;
        bad_request     <= 1'b1;
        last_cell       <= 1'b1;
      end else begin
        cell_year       <= y_c;
        cell_month      <= m_c;
        cell_day        <= d_c[DAY_W-1:0];
        cell_this_month <= inm_c;
        date_ok         <= (y_c >= YEAR_MIN) && (y_c <= YEAR_MAX);
        bad_request     <= 1'b0;
        last_cell       <= last_now;
      end
    end
  end

endmodule

### src/month_calendar_grid_generator_unit.sv
// ----------------------------------------------------------------------------
// month_calendar_grid_generator_unit
// six-week sunday-first calendar grid for one gregorian year and month
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------------
//   req     | in        | req_valid / req_ready   | req_year, req_month
//   cell    | out       | cell_valid / cell_ready | cell_year, cell_month, cell_day,
//           |           |                         | cell_this_month, date_ok,
//           |           |                         | bad_request, last_cell
//
// each request yields GRID_CELLS cells at one cell per cycle while cell_ready
// does not stall (a rejected request yields one cell); the cell counter paces
// the cells. a request passes through the setup pipeline, which overlaps the
// previous request's cells. synchronous active-high reset empties the pipeline
// and the output register. a stall on cell_ready holds the counter; the setup
// pipeline keeps filling until it backs up to req_ready.
// ----------------------------------------------------------------------------
module month_calendar_grid_generator_unit import mcg_pkg::*; #(
  parameter int GRID_CELLS = 42
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic [YEAR_W-1:0]  req_year,
  input  logic [MONTH_W-1:0] req_month,
  output logic               cell_valid,
  input  logic               cell_ready,
  output logic [YEAR_W-1:0]  cell_year,
  output logic [MONTH_W-1:0] cell_month,
  output logic [DAY_W-1:0]   cell_day,
  output logic               cell_this_month,
  output logic               date_ok,
  output logic               bad_request,
  output logic               last_cell
);

  // grid parameters between setup and emitter
  logic        prm_valid;
  logic        prm_ready;
  req_params_t prm;

  // weekday of the 1st, leap flag and neighbor months
  mcg_setup u_setup (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_year  (req_year),
    .req_month (req_month),
    .prm_valid (prm_valid),
    .prm_ready (prm_ready),
    .prm       (prm)
  );

  // one cell per cycle, unless cell_ready stalls, into the output register
  mcg_cells #(
    .GRID_CELLS (GRID_CELLS)
  ) u_cells (
    .clk             (clk),
    .rst             (rst),
    .prm_valid       (prm_valid),
    .prm_ready       (prm_ready),
    .prm             (prm),
    .cell_valid      (cell_valid),
    .cell_ready      (cell_ready),
    .cell_year       (cell_year),
    .cell_month      (cell_month),
    .cell_day        (cell_day),
    .cell_this_month (cell_this_month),
    .date_ok         (date_ok),
    .bad_request     (bad_request),
    .last_cell       (last_cell)
  );

  // a rejected request is a lone, empty cell
  a_bad_lone: assert property (@(posedge clk) disable iff (rst)
    cell_valid && bad_request |-> last_cell && (cell_year == '0) && !date_ok)
    else $error("rejected request cell not lone or not empty");

  // cells of the requested month always carry a valid year
  a_inm_ok: assert property (@(posedge clk) disable iff (rst)
    cell_valid && cell_this_month |-> date_ok && (cell_day != '0))
    else $error("in-month cell with invalid date");

  // the emitter never leaves a gap inside one request
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    cell_valid && cell_ready && !last_cell |=> cell_valid)
    else $error("gap inside a request's cells");

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the month calendar grid generator
//
// requests go in over a valid/ready channel with random gaps. every accepted
// request is expanded into its expected cells, which wait in a queue. each
// cell that comes out is matched field by field against the oldest entry.
// the cell side stalls at random too, with quiet stretches in between.
// ----------------------------------------------------------------------------
module tb_top;
  import mcg_pkg::*;

  localparam int GRID_CELLS = 42;
  localparam int MAX_WAIT   = 17;
  // drain allowance: setup pipeline plus one full grid
  localparam int DRAIN_CYCLES = 60;

  // weekday shift of the 1st, jan..dec, for a sunday-based count
  localparam int FIRST_SHIFT[12] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic               in_m;
    logic               ok;
    logic               bad;
    logic               last;
  } grid_cell_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_ready;
  logic [YEAR_W-1:0]  req_year = '0;
  logic [MONTH_W-1:0] req_month = '0;
  logic               cell_valid;
  logic               cell_ready = 1'b0;
  logic [YEAR_W-1:0]  cell_year;
  logic [MONTH_W-1:0] cell_month;
  logic [DAY_W-1:0]   cell_day;
  logic               cell_this_month;
  logic               date_ok;
  logic               bad_request;
  logic               last_cell;

  grid_cell_t pending_cells[$];
  int         mismatch_cnt = 0;
  // when set, neither side inserts wait cycles
  bit         no_idle = 1'b0;

  month_calendar_grid_generator_unit #(
    .GRID_CELLS(GRID_CELLS)
  ) i_dut (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_ready      (req_ready),
    .req_year       (req_year),
    .req_month      (req_month),
    .cell_valid     (cell_valid),
    .cell_ready     (cell_ready),
    .cell_year      (cell_year),
    .cell_month     (cell_month),
    .cell_day       (cell_day),
    .cell_this_month(cell_this_month),
    .date_ok        (date_ok),
    .bad_request    (bad_request),
    .last_cell      (last_cell)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // calendar arithmetic for the expected grid
  // --------------------------------------------------------------------------
  function automatic int days_of(int y, int m);
    bit leap;
    leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    case (m)
      2:           return leap ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  // weekday of the 1st, sunday = 0; jan and feb count against the prior year
  function automatic int weekday_of_first(int y, int m);
    int yy;
    yy = (m < 3) ? y - 1 : y;
    return (yy + yy / 4 - yy / 100 + yy / 400 + FIRST_SHIFT[m - 1] + 1) % 7;
  endfunction

  // expand one accepted request into the cells it must produce
  function automatic void queue_month_grid(logic [YEAR_W-1:0] y, logic [MONTH_W-1:0] m);
    grid_cell_t c;
    int lead, len, plen, py, pm, ny, nm, cy, cm, cd;
    c = '0;
    if (y < YEAR_MIN || y > YEAR_MAX || m < MONTH_JAN || m > MONTH_DEC) begin
      // rejected request: one lone flagged cell, all date fields zero
      c.bad  = 1'b1;
      c.last = 1'b1;
      pending_cells.insert(pending_cells.size(), c);
      return;
    end
    lead = weekday_of_first(y, m);
    len  = days_of(y, m);
    py   = (m == MONTH_JAN) ? y - 1 : y;
    pm   = (m == MONTH_JAN) ? 12 : m - 1;
    ny   = (m == MONTH_DEC) ? y + 1 : y;
    nm   = (m == MONTH_DEC) ? 1 : m + 1;
    plen = days_of(py, pm);
    for (int k = 0; k < GRID_CELLS; k++) begin
      if (k < lead) begin
        cy = py; cm = pm; cd = plen - lead + k + 1;
      end else if (k < lead + len) begin
        cy = y;  cm = m;  cd = k - lead + 1;
      end else begin
        cy = ny; cm = nm; cd = k - lead - len + 1;
      end
      c.year  = cy[YEAR_W-1:0];
      c.month = cm[MONTH_W-1:0];
      c.day   = cd[DAY_W-1:0];
      c.in_m  = (k >= lead) && (k < lead + len);
      c.ok    = (cy >= 1) && (cy <= 9999);
      c.bad   = 1'b0;
      c.last  = (k == GRID_CELLS - 1);
      pending_cells.insert(pending_cells.size(), c);
    end
  endfunction

  // --------------------------------------------------------------------------
  // request driver: random gap, then hold valid until accepted
  // --------------------------------------------------------------------------
  task automatic send_request(input logic [YEAR_W-1:0] y, input logic [MONTH_W-1:0] m);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_year  <= y;
    req_month <= m;
    do @(posedge clk); while (!req_ready);
    queue_month_grid(y, m);
  endtask

  // --------------------------------------------------------------------------
  // cell side: random stall before each cell
  // --------------------------------------------------------------------------
  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        cell_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      cell_ready <= 1'b1;
      do @(posedge clk); while (!cell_valid);
    end
  end

  // --------------------------------------------------------------------------
  // cell checker
  // --------------------------------------------------------------------------
  function automatic void flag_field(string name, int want, int got);
    if (want != got) begin
      mismatch_cnt++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    grid_cell_t want;
    if (!rst && cell_valid && cell_ready) begin
      if (pending_cells.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: unexpected cell, expected none, actual %0d-%0d-%0d bad=%0b",
                 $time, cell_year, cell_month, cell_day, bad_request);
      end else begin
        want = pending_cells.pop_front();
        flag_field("cell_year",       want.year,  cell_year);
        flag_field("cell_month",      want.month, cell_month);
        flag_field("cell_day",        want.day,   cell_day);
        flag_field("cell_this_month", want.in_m,  cell_this_month);
        flag_field("date_ok",         want.ok,    date_ok);
        flag_field("bad_request",     want.bad,   bad_request);
        flag_field("last_cell",       want.last,  last_cell);
      end
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // out-of-range years and months, including all-ones inputs
  task automatic test_rejected();
    send_request(14'd0, 4'd1);
    send_request(14'd10000, 4'd5);
    send_request(14'd16383, 4'd15);
    send_request(14'd5, 4'd0);
    send_request(14'd5, 4'd13);
    send_request(14'd0, 4'd0);
  endtask

  // grids that spill into year 0 or year 10000, and the extreme years
  task automatic test_range_edges();
    send_request(YEAR_MIN, MONTH_JAN);
    send_request(YEAR_MAX, MONTH_DEC);
    send_request(YEAR_MAX, MONTH_JAN);
  endtask

  // century and 400-year rules, a feb starting on sunday, a saturday start
  task automatic test_leap_rule();
    send_request(14'd1900, MONTH_FEB);
    send_request(14'd2000, MONTH_FEB);
    send_request(14'd2015, MONTH_FEB);
    send_request(14'd2020, 4'd8);
  endtask

  // every month of a leap year
  task automatic test_all_months();
    for (int m = 1; m <= 12; m++) send_request(14'd2024, m[MONTH_W-1:0]);
  endtask

  // mostly well-formed requests, biased toward the edges, some rejects
  task automatic test_random_traffic();
    logic [YEAR_W-1:0]  y;
    logic [MONTH_W-1:0] m;
    int sel;
    for (int blk = 0; blk < 8; blk++) begin
      // every third block runs with no idling on either side
      no_idle = (blk % 3 == 2);
      for (int n = 0; n < 40; n++) begin
        sel = $urandom_range(0, 9);
        m   = MONTH_W'($urandom_range(1, 12));
        case (sel)
          0: y = YEAR_W'($urandom_range(1, 3));
          1: y = YEAR_W'($urandom_range(9997, 9999));
          2: y = YEAR_W'($urandom_range(1, 99) * 100);
          3: begin
            if ($urandom_range(0, 1)) begin
              y = ($urandom_range(0, 1)) ? 14'd0 : YEAR_W'($urandom_range(10000, 16383));
              m = MONTH_W'($urandom_range(0, 15));
            end else begin
              y = YEAR_W'($urandom_range(1, 9999));
              m = ($urandom_range(0, 1)) ? 4'd0 : MONTH_W'($urandom_range(13, 15));
            end
          end
          default: y = YEAR_W'($urandom_range(1, 9999));
        endcase
        send_request(y, m);
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_rejected();
    test_range_edges();
    test_leap_rule();
    test_all_months();
    test_random_traffic();
    req_valid <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
